FILE: hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared types, constants and helpers of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  // fixed point format and cordic length
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_N     = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
  localparam int GUARD        = 8;

  // cordic datapath widths: x/y carry guard bits plus gain growth
  localparam int CW = 32 + GUARD + 3;
  localparam int AW = 34;

  // pipeline layout
  localparam int DIV_STEPS = 32;
  localparam int NST       = DIV_STEPS + 6;
  localparam int ST_POST   = CORDIC_N + 4;

  // scaling constants
  localparam logic [29:0]        INV_GAIN = 30'd652032874;
  localparam logic signed [AW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [31:0] DEG_K    = 32'sd961263669;
  localparam logic signed [31:0] GRAD_K   = 32'sd1068070743;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4,
    CMD_ARG = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ANG_RAD  = 2'd0,
    ANG_DEG  = 2'd1,
    ANG_GRAD = 2'd2
  } ang_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               inv;
    logic               ovf;
  } res_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               o;
  } sat_t;

  localparam logic signed [71:0] SMAX = 72'sd2147483647;
  localparam logic signed [71:0] SMIN = -72'sd2147483648;

  // clamp a wide signed value to 32 bits
  function automatic sat_t sat_w(input logic signed [71:0] v);
    sat_t r;
    if (v > SMAX) begin
      r.v = 32'sh7FFFFFFF;
      r.o = 1'b1;
    end else if (v < SMIN) begin
      r.v = 32'sh80000000;
      r.o = 1'b1;
    end else begin
      r.v = 32'(v);
      r.o = 1'b0;
    end
    return r;
  endfunction

  // arctangent of 2^-i in q30 radians
  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h3243F6A8;
      1:  t = 32'h1DAC6705;
      2:  t = 32'h0FADBAFC;
      3:  t = 32'h07F56EA6;
      4:  t = 32'h03FEAB76;
      5:  t = 32'h01FFD55B;
      6:  t = 32'h00FFFAAA;
      7:  t = 32'h007FFF55;
      8:  t = 32'h003FFFEA;
      9:  t = 32'h001FFFFD;
      10: t = 32'h000FFFFF;
      11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF;
      13: t = 32'h0001FFFF;
      14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF;
      16: t = 32'h00003FFF;
      17: t = 32'h00001FFF;
      18: t = 32'h00000FFF;
      19: t = 32'h000007FF;
      20: t = 32'h000003FF;
      21: t = 32'h000001FF;
      22: t = 32'h000000FF;
      23: t = 32'h0000007F;
      24: t = 32'h0000003F;
      25: t = 32'h0000001F;
      26: t = 32'h0000000F;
      27: t = 32'h00000008;
      28: t = 32'h00000004;
      29: t = 32'h00000002;
      default: t = 32'h0;
    endcase
    return AW'(t);
  endfunction

endpackage

FILE: hdl/complex_arith_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// pipelined complex add, sub, mul, div, magnitude and argument in q15.16
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  req       in   req_valid/req_stall    cmd, a_re, a_im, b_re, b_im
//  rsp       out  rsp_valid/rsp_stall    r_re, r_im, invalid, overflow
//  cfg       in   cfg_wen                cfg_wdata (angle_mode)
//
//  every opcode has the same latency, set by the 32 step restoring divider;
//  one beat enters per cycle while req_stall is low, cordic lane beside it.
//  a one entry skid register behind the last stage holds a stalled beat,
//  while it is full the pipeline freezes and req_stall is high.
//  rst is synchronous and clears valid bits, the skid full flag and angle_mode.
//
module complex_arith_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] r_re,
  output logic signed [31:0] r_im,
  output logic               invalid,
  output logic               overflow,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_wdata
);
  import cau_pkg::*;

  localparam int XM_W = CW - 1;
  localparam int XL_W = 21;
  localparam int XH_W = XM_W - XL_W;

  logic             en;
  logic [NST:1]     vld;
  logic [1:0]       angle_mode;
  logic [2:0]       cmd_q [1:NST-1];
  logic             dz_q  [1:NST-1];
  logic             az_q  [1:ST_POST-1];
  res_t             er    [1:NST-1];
  res_t             fin;
  res_t             skid;
  logic             skid_full;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_mode <= ANG_RAD;
    end else if (cfg_wen) begin
      angle_mode <= cfg_wdata;
    end
  end

  // valid bits and skid control
  assign en = !skid_full;
  assign req_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      skid_full <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[NST-1:1], req_valid};
      end
      if (skid_full && !rsp_stall) begin
        skid_full <= 1'b0;
      end else if (!skid_full && vld[NST] && rsp_stall) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && vld[NST] && rsp_stall) begin
      skid <= fin;
    end
  end

  assign rsp_valid = skid_full | vld[NST];
  assign r_re      = skid_full ? skid.re  : fin.re;
  assign r_im      = skid_full ? skid.im  : fin.im;
  assign invalid   = skid_full ? skid.inv : fin.inv;
  assign overflow  = skid_full ? skid.ovf : fin.ovf;

  // ---------------------------------------------------------------- stage 1
  logic signed [32:0]   as_re, as_im;
  sat_t                 as_sre, as_sim;
  logic signed [CW-1:0] xs, ys, x0, y0;
  logic signed [AW-1:0] a0;
  logic signed [63:0]   p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [CW-1:0] cx [0:CORDIC_N];
  logic signed [CW-1:0] cy [0:CORDIC_N];
  logic signed [AW-1:0] ca [0:CORDIC_N];

  // add and sub straight from the beat
  always_comb begin
    if (cmd == CMD_SUB) begin
      as_re = {a_re[31], a_re} - {b_re[31], b_re};
      as_im = {a_im[31], a_im} - {b_im[31], b_im};
    end else begin
      as_re = {a_re[31], a_re} + {b_re[31], b_re};
      as_im = {a_im[31], a_im} + {b_im[31], b_im};
    end
    as_sre = sat_w(72'(as_re));
    as_sim = sat_w(72'(as_im));
  end

  // cordic quadrant fold into the right half plane
  always_comb begin
    xs = CW'(a_re) <<< GUARD;
    ys = CW'(a_im) <<< GUARD;
    if (a_re[31]) begin
      if (!a_im[31]) begin
        x0 = ys;
        y0 = -xs;
        a0 = HALF_PI;
      end else begin
        x0 = -ys;
        y0 = xs;
        a0 = -HALF_PI;
      end
    end else begin
      x0 = xs;
      y0 = ys;
      a0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_q[1] <= cmd;
      dz_q[1]  <= (b_re == 32'sd0) && (b_im == 32'sd0);
      az_q[1]  <= (a_re == 32'sd0) && (a_im == 32'sd0);
      p_rr     <= a_re * b_re;
      p_ii     <= a_im * b_im;
      p_ri     <= a_re * b_im;
      p_ir     <= a_im * b_re;
      sq_r     <= b_re * b_re;
      sq_i     <= b_im * b_im;
      cx[0]    <= x0;
      cy[0]    <= y0;
      ca[0]    <= a0;
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
        er[1] <= '{re: as_sre.v, im: as_sim.v, inv: 1'b0, ovf: as_sre.o | as_sim.o};
      end else begin
        er[1] <= '0;
      end
    end
  end

  // control and flag delay lines
  for (genvar s = 2; s < NST; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (en) begin
        cmd_q[s] <= cmd_q[s-1];
        dz_q[s]  <= dz_q[s-1];
      end
    end
  end

  for (genvar s = 2; s < ST_POST; s++) begin : g_az
    always_ff @(posedge clk) begin
      if (en) begin
        az_q[s] <= az_q[s-1];
      end
    end
  end

  // -------------------------------------------------------- mul and div sums
  logic signed [65:0] mr, mi;
  logic signed [64:0] n_re, n_im;
  logic [63:0]        den2;

  always_ff @(posedge clk) begin
    if (en) begin
      mr   <= 66'(p_rr) - 66'(p_ii) + (66'sd1 <<< (FRAC_BITS - 1));
      mi   <= 66'(p_ri) + 66'(p_ir) + (66'sd1 <<< (FRAC_BITS - 1));
      n_re <= 65'(p_rr) + 65'(p_ii);
      n_im <= 65'(p_ir) - 65'(p_ri);
      den2 <= 64'(sq_r + sq_i);
    end
  end

  // mul rounding and clamp
  sat_t mul_sre, mul_sim;
  always_comb begin
    mul_sre = sat_w(72'(mr >>> FRAC_BITS));
    mul_sim = sat_w(72'(mi >>> FRAC_BITS));
  end

  // --------------------------------------------------------- divider front
  logic [63:0] mag3 [0:1];
  logic [1:0]  neg3;
  logic [63:0] den3;

  always_ff @(posedge clk) begin
    if (en) begin
      mag3[0] <= n_re[64] ? 64'(-n_re) : 64'(n_re);
      mag3[1] <= n_im[64] ? 64'(-n_im) : 64'(n_im);
      neg3    <= {n_im[64], n_re[64]};
      den3    <= den2;
    end
  end

  logic [63:0] r_d   [0:DIV_STEPS][0:1];
  logic [31:0] lo_d  [0:DIV_STEPS][0:1];
  logic [31:0] q_d   [0:DIV_STEPS][0:1];
  logic [63:0] den_d [0:DIV_STEPS];
  logic [1:0]  neg_d [0:DIV_STEPS];
  logic [1:0]  pov_d [0:DIV_STEPS];

  // upper part of the numerator must stay below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        r_d[0][p]  <= mag3[p] >> (32 - FRAC_BITS);
        lo_d[0][p] <= 32'(mag3[p] << FRAC_BITS);
        q_d[0][p]  <= '0;
        pov_d[0][p] <= (mag3[p] >> (32 - FRAC_BITS)) >= den3;
      end
      den_d[0] <= den3;
      neg_d[0] <= neg3;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [63:0] t  [0:1];
    logic [1:0]  ge;
    always_comb begin
      for (int p = 0; p < 2; p++) begin
        t[p]  = {r_d[k][p][62:0], lo_d[k][p][31]};
        ge[p] = t[p] >= den_d[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int p = 0; p < 2; p++) begin
          r_d[k+1][p]  <= ge[p] ? (t[p] - den_d[k]) : t[p];
          lo_d[k+1][p] <= lo_d[k][p] << 1;
          q_d[k+1][p]  <= {q_d[k][p][30:0], ge[p]};
        end
        den_d[k+1] <= den_d[k];
        neg_d[k+1] <= neg_d[k];
        pov_d[k+1] <= pov_d[k];
      end
    end
  end

  // round half away from zero on the magnitude
  logic [32:0] qr [0:1];
  logic [1:0]  neg_r, pov_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        qr[p] <= {1'b0, q_d[DIV_STEPS][p]} +
                 33'((r_d[DIV_STEPS][p] << 1) >= den_d[DIV_STEPS]);
      end
      neg_r <= neg_d[DIV_STEPS];
      pov_r <= pov_d[DIV_STEPS];
    end
  end

  // sign and clamp one quotient part
  function automatic sat_t div_fin(input logic [32:0] q, input logic ng, input logic pv);
    sat_t r;
    if (pv || (!ng && q > 33'h07FFFFFFF) || (ng && q > 33'h080000000)) begin
      r.v = ng ? 32'sh80000000 : 32'sh7FFFFFFF;
      r.o = 1'b1;
    end else begin
      r.v = ng ? 32'(-q) : 32'(q);
      r.o = 1'b0;
    end
    return r;
  endfunction

  sat_t dv_re, dv_im;
  always_comb begin
    dv_re = div_fin(qr[0], neg_r[0], pov_r[0]);
    dv_im = div_fin(qr[1], neg_r[1], pov_r[1]);
  end

  // ---------------------------------------------------------- cordic steps
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    logic signed [CW-1:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          ca[i+1] <= ca[i] + atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          ca[i+1] <= ca[i] - atan_q30(i);
        end
      end
    end
  end

  // --------------------------------------------------- gain and unit scaling
  logic [XM_W-1:0]    xm;
  logic [XH_W+29:0]   mh;
  logic [XL_W+29:0]   ml;
  logic signed [65:0] ap;
  logic               rad;
  logic [71:0]        msum;
  logic [34:0]        mag_v;
  logic signed [65:0] arg_v;

  assign xm  = cx[CORDIC_N][XM_W-1:0];
  assign rad = !(angle_mode == ANG_DEG || angle_mode == ANG_GRAD);

  always_ff @(posedge clk) begin
    if (en) begin
      mh <= xm[XM_W-1:XL_W] * INV_GAIN;
      ml <= xm[XL_W-1:0] * INV_GAIN;
      if (rad) begin
        ap <= 66'(ca[CORDIC_N]);
      end else if (angle_mode == ANG_DEG) begin
        ap <= ca[CORDIC_N] * DEG_K;
      end else begin
        ap <= ca[CORDIC_N] * GRAD_K;
      end
    end
  end

  assign msum = (72'(mh) << XL_W) + 72'(ml) + (72'd1 << (29 + GUARD));

  always_ff @(posedge clk) begin
    if (en) begin
      mag_v <= 35'(msum >> (30 + GUARD));
      if (rad) begin
        arg_v <= (ap + (66'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      end else begin
        arg_v <= (ap + (66'sd1 <<< (53 - FRAC_BITS))) >>> (54 - FRAC_BITS);
      end
    end
  end

  sat_t mg_s, ag_s;
  always_comb begin
    mg_s = sat_w(72'(mag_v));
    ag_s = sat_w(72'(arg_v));
  end

  // ------------------------------------------------ early result delay line
  for (genvar s = 2; s < NST; s++) begin : g_er
    always_ff @(posedge clk) begin
      if (en) begin
        if (s == 3 && cmd_q[s-1] == CMD_MUL) begin
          er[s] <= '{re: mul_sre.v, im: mul_sim.v, inv: 1'b0,
                     ovf: mul_sre.o | mul_sim.o};
        end else if (s == ST_POST && cmd_q[s-1] == CMD_MAG) begin
          er[s] <= '{re: mg_s.v, im: 32'sd0, inv: 1'b0, ovf: mg_s.o};
        end else if (s == ST_POST && cmd_q[s-1] == CMD_ARG) begin
          if (az_q[ST_POST-1]) begin
            er[s] <= '0;
          end else begin
            er[s] <= '{re: ag_s.v, im: 32'sd0, inv: 1'b0, ovf: ag_s.o};
          end
        end else begin
          er[s] <= er[s-1];
        end
      end
    end
  end

  // ------------------------------------------------------------ last stage
  always_ff @(posedge clk) begin
    if (en) begin
      if (cmd_q[NST-1] == CMD_DIV) begin
        if (dz_q[NST-1]) begin
          fin <= '{re: 32'sd0, im: 32'sd0, inv: 1'b1, ovf: 1'b0};
        end else begin
          fin <= '{re: dv_re.v, im: dv_im.v, inv: 1'b0, ovf: dv_re.o | dv_im.o};
        end
      end else begin
        fin <= er[NST-1];
      end
    end
  end

endmodule

FILE: hdl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// port level checks of the complex arithmetic unit
// ----------------------------------------------------------------------------
module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic [2:0]         cmd,
  input logic signed [31:0] a_re,
  input logic signed [31:0] a_im,
  input logic signed [31:0] b_re,
  input logic signed [31:0] b_im,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] r_re,
  input logic signed [31:0] r_im,
  input logic               invalid,
  input logic               overflow,
  input logic               cfg_wen,
  input logic [1:0]         cfg_wdata
);

  // a stalled result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(r_re) && $stable(r_im)
      && $stable(invalid) && $stable(overflow))
    else $error("stalled result beat changed");

  // the block only pushes back while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no result pending");

  // a division by zero gives a clean zero result
  a_div0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && invalid |-> r_re == 32'sd0 && r_im == 32'sd0 && !overflow)
    else $error("invalid result not zeroed");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("output active after reset");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);

FILE: test/complex_arith_unit_checker.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_checker
// watches the request, response and config ports of the complex arithmetic
// unit, predicts each response from the accepted request and the current
// angle unit, and compares every response beat field by field in order
// ----------------------------------------------------------------------------
module complex_arith_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic signed [31:0] r_re,
  input  logic signed [31:0] r_im,
  input  logic               invalid,
  input  logic               overflow,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_wdata,
  output int                 errors,
  output int                 pending
);
  import cau_pkg::*;

  localparam longint ONE_OVER_GAIN = 64'd652032874;
  localparam longint QUARTER_TURN  = 64'd1686629713;
  localparam longint RAD_TO_DEG    = 64'd961263669;
  localparam longint RAD_TO_GRAD   = 64'd1068070743;

  // arctangent of 2^-i, q30 radians
  localparam longint ARCTAN [20] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
  };

  logic [1:0] angle_unit;
  res_t       results_due[$];

  // clamp to 32 bits, flag on clamp
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // rounded quotient num * 2^16 / den, magnitude rounded half away from zero
  function automatic logic signed [31:0] quotient(input logic signed [127:0] num,
                                                  input logic [127:0] den,
                                                  inout logic ovf);
    logic [127:0]        mag;
    logic [127:0]        q;
    logic [127:0]        rem;
    logic signed [127:0] sq;
    mag = (num < 0) ? -num : num;
    mag = mag << FRAC_BITS;
    q   = mag / den;
    rem = mag % den;
    if (rem >= den - rem) q = q + 1;
    sq = (num < 0) ? -$signed(q) : $signed(q);
    return clamp32(sq, ovf);
  endfunction

  // cordic vectoring: gained radius and q30 angle
  function automatic void rotate_to_axis(input longint x0, input longint y0,
                                         output longint xr, output longint ang);
    longint x;
    longint y;
    longint t;
    longint dx;
    longint dy;
    x   = x0;
    y   = y0;
    ang = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        ang = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + ARCTAN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - ARCTAN[i];
      end
    end
    xr = x;
  endfunction

  // expected response for one request beat
  function automatic res_t complex_result(input logic [2:0] op,
                                          input logic signed [31:0] ar,
                                          input logic signed [31:0] ai,
                                          input logic signed [31:0] br,
                                          input logic signed [31:0] bi,
                                          input logic [1:0] unit);
    res_t                r;
    logic                ovf;
    logic signed [127:0] w;
    logic [127:0]        den;
    longint              xr;
    longint              ang;
    r   = '0;
    ovf = 1'b0;
    case (op)
      CMD_ADD: begin
        r.re = clamp32(128'(ar) + 128'(br), ovf);
        r.im = clamp32(128'(ai) + 128'(bi), ovf);
      end
      CMD_SUB: begin
        r.re = clamp32(128'(ar) - 128'(br), ovf);
        r.im = clamp32(128'(ai) - 128'(bi), ovf);
      end
      CMD_MUL: begin
        w = 128'(ar) * 128'(br) - 128'(ai) * 128'(bi) + (128'sd1 <<< (FRAC_BITS - 1));
        r.re = clamp32(w >>> FRAC_BITS, ovf);
        w = 128'(ar) * 128'(bi) + 128'(ai) * 128'(br) + (128'sd1 <<< (FRAC_BITS - 1));
        r.im = clamp32(w >>> FRAC_BITS, ovf);
      end
      CMD_DIV: begin
        den = 128'(128'(br) * 128'(br) + 128'(bi) * 128'(bi));
        if (den == 0) begin
          r.inv = 1'b1;
        end else begin
          r.re = quotient(128'(ar) * 128'(br) + 128'(ai) * 128'(bi), den, ovf);
          r.im = quotient(128'(ai) * 128'(br) - 128'(ar) * 128'(bi), den, ovf);
        end
      end
      CMD_MAG: begin
        rotate_to_axis(longint'(ar) * 256, longint'(ai) * 256, xr, ang);
        w = (128'(xr) * ONE_OVER_GAIN + (128'sd1 <<< 37)) >>> 38;
        r.re = clamp32(w, ovf);
      end
      CMD_ARG: begin
        if (ar != 0 || ai != 0) begin
          rotate_to_axis(longint'(ar) * 256, longint'(ai) * 256, xr, ang);
          if (unit == ANG_DEG)
            w = (128'(ang) * RAD_TO_DEG + (128'sd1 <<< 37)) >>> 38;
          else if (unit == ANG_GRAD)
            w = (128'(ang) * RAD_TO_GRAD + (128'sd1 <<< 37)) >>> 38;
          else
            w = (128'(ang) + (128'sd1 <<< 13)) >>> 14;
          r.re = clamp32(w, ovf);
        end
      end
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  assign pending = results_due.size();

  // track config, queue predictions, compare response beats
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      angle_unit <= ANG_RAD;
      errors     <= 0;
      results_due.delete();
    end else begin
      if (cfg_wen) angle_unit <= cfg_wdata;
      if (req_valid && !req_stall)
        results_due.push_back(complex_result(cmd, a_re, a_im, b_re, b_im, angle_unit));
      if (rsp_valid && !rsp_stall) begin
        if (results_due.size() == 0) begin
          if (errors < 10) $display("unexpected response beat re=%h im=%h", r_re, r_im);
          errors <= errors + 1;
        end else begin
          want = results_due.pop_front();
          if (r_re !== want.re || r_im !== want.im || invalid !== want.inv ||
              overflow !== want.ovf) begin
            if (errors < 10)
              $display("mismatch: exp re=%h im=%h inv=%b ovf=%b got re=%h im=%h inv=%b ovf=%b",
                       want.re, want.im, want.inv, want.ovf, r_re, r_im, invalid, overflow);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: test/complex_arith_unit_top_tb.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top_tb
// drives directed corner cases and random operations through the complex
// arithmetic unit under random request gaps and response stalls, across
// every angle unit setting; the checker beside the unit does the scoring
// ----------------------------------------------------------------------------
module complex_arith_unit_top_tb;
  import cau_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         cmd = CMD_ADD;
  logic signed [31:0] a_re = '0;
  logic signed [31:0] a_im = '0;
  logic signed [31:0] b_re = '0;
  logic signed [31:0] b_im = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] r_re;
  logic signed [31:0] r_im;
  logic               invalid;
  logic               overflow;
  logic               cfg_wen = 1'b0;
  logic [1:0]         cfg_wdata = ANG_RAD;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  bit                 calm = 1'b0;
  int                 stall_left = 0;

  complex_arith_unit_top dut (.*);

  complex_arith_unit_checker scoreboard (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // response side stalls a random count before each beat
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left  = 0;
    end else begin
      if (rsp_valid && !rsp_stall) stall_left = calm ? 0 : $urandom_range(6);
      else if (stall_left > 0) stall_left--;
      rsp_stall <= (stall_left > 0);
    end
  end

  // one request beat after a random gap
  task automatic send_op(input logic [2:0] op, input logic signed [31:0] ar,
                         input logic signed [31:0] ai, input logic signed [31:0] br,
                         input logic signed [31:0] bi);
    int gap;
    gap = calm ? 0 : $urandom_range(6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= op;
    a_re      <= ar;
    a_im      <= ai;
    b_re      <= br;
    b_im      <= bi;
    forever begin
      @(negedge clk);
      if (!req_stall) break;
    end
    @(posedge clk);
  endtask

  // drain the pipeline then write the angle unit
  task automatic set_angle_unit(input logic [1:0] unit);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= unit;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  // operand with a spread of magnitudes
  function automatic logic signed [31:0] operand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(2097151)) - 32'sd1048576;
      2: return $signed($urandom_range(262143)) - 32'sd131072;
      3: return $signed($urandom_range(15)) - 32'sd8;
      4: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(3)
                                  : 32'sh80000000 + $urandom_range(3);
      default: return $urandom_range(3) == 0 ? 32'sd0 : $urandom();
    endcase
  endfunction

  initial begin
    logic [2:0]         op;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners in the reset angle unit
    send_op(CMD_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_op(CMD_SUB, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    send_op(CMD_ADD, 32'sd65536, -32'sd65536, 32'sd0, 32'sd0);
    send_op(CMD_MUL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_op(CMD_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_op(CMD_MUL, 32'sd98304, -32'sd32768, 32'sd1, 32'sd1);
    send_op(CMD_DIV, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0);
    send_op(CMD_DIV, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 32'sd0);
    send_op(CMD_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_op(CMD_DIV, 32'sd65536, 32'sd0, 32'sd196608, -32'sd1);
    send_op(CMD_MAG, 32'sh80000000, 32'sh80000000, 32'sd0, 32'sd0);
    send_op(CMD_MAG, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0, 32'sd0);
    send_op(CMD_MAG, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_op(CMD_MAG, -32'sd196608, 32'sd262144, 32'sd0, 32'sd0);
    send_op(CMD_ARG, 32'sd0, 32'sd0, 32'sd5, 32'sd5);
    send_op(CMD_ARG, -32'sd65536, 32'sd0, 32'sd0, 32'sd0);
    send_op(CMD_ARG, -32'sd65536, -32'sd1, 32'sd0, 32'sd0);
    send_op(CMD_ARG, 32'sd0, -32'sd65536, 32'sd0, 32'sd0);
    send_op(CMD_ARG, 32'sh80000000, 32'sh7FFFFFFF, 32'sd0, 32'sd0);
    send_op(3'd6, 32'sd100, 32'sd100, 32'sd100, 32'sd100);
    send_op(3'd7, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 32'sd1);

    // random operations under each angle unit, unused unit code last
    for (int u = 0; u < 5; u++) begin
      set_angle_unit(u == 4 ? ANG_RAD : 2'(u == 0 ? ANG_GRAD : u - 1));
      for (int n = 0; n < 350; n++) begin
        calm = (n >= 150 && n < 200);
        op = $urandom_range(15) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(5));
        br = operand();
        bi = operand();
        if (op == CMD_DIV && $urandom_range(9) == 0) begin
          br = '0;
          bi = '0;
        end
        send_op(op, operand(), operand(), br, bi);
      end
      calm = 1'b0;
    end
    set_angle_unit(2'd3);
    for (int n = 0; n < 60; n++) send_op(CMD_ARG, operand(), operand(), operand(), operand());

    // drain and settle
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/cau_pkg.sv
hdl/complex_arith_unit_top.sv
hdl/cau_checker.sv
test/complex_arith_unit_checker.sv
test/complex_arith_unit_top_tb.sv
